/* src/hhbs_pkg.sv */
// Shared types, codes and constants for the HTTP header/body splitter.
package hhbs_pkg;

  localparam int STATUS_MAX_DEF = 63;
  localparam int LIMIT_W = 10;
  localparam int SLEN_W = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd600;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [31:0] END_CRLF = 32'h0D0A_0D0A;
  localparam logic [15:0] END_LFLF = 16'h0A0A;

  localparam logic [2:0] CLS_STATUS = 3'd0;
  localparam logic [2:0] CLS_HEADER = 3'd1;
  localparam logic [2:0] CLS_FINAL = 3'd2;
  localparam logic [2:0] CLS_BODY = 3'd3;
  localparam logic [2:0] CLS_RESTART = 3'd4;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        byte_out;
    logic [2:0]        byte_class;
    logic [SLEN_W-1:0] status_length;
    logic              header_gave_up;
    logic [31:0]       body_count;
    logic              block_end;
  } out_item_t;

endpackage

/* src/hhbs_if.sv */
// Valid/ready channel interfaces for input and result items.
interface hhbs_in_if import hhbs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hhbs_out_if import hhbs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* src/hhbs_in_stage.sv */
// Input register stage for incoming items.
module hhbs_in_stage import hhbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  hhbs_in_if.sink  din,
  input  logic     s_ready,
  output logic     s_valid,
  output in_item_t s_item
);

  assign din.ready = !s_valid || s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      s_valid <= 1'b1;
    end else if (s_ready) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s_item <= din.data;
    end
  end

endmodule

/* src/hhbs_classify.sv */
// Running header/body state, byte classification and result register.
module hhbs_classify import hhbs_pkg::*; #(
  parameter int STATUS_MAX = STATUS_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] header_limit,
  input  logic               s_valid,
  input  in_item_t           s_item,
  output logic               s_ready,
  hhbs_out_if.source         dout
);

  localparam int SW = $clog2(STATUS_MAX + 1);
  localparam logic [SW-1:0] SMAX = SW'(STATUS_MAX);

  logic [LIMIT_W-1:0] header_count, header_count_next;
  logic [31:0]        last_bytes, last_bytes_next;
  logic [SW-1:0]      status_count, status_count_next;
  logic               status_open, status_open_next;
  logic               in_body, in_body_next;
  logic [31:0]        body_total, body_total_next;

  logic               res_valid;
  out_item_t          res_item;
  out_item_t          res_next;
  logic               take;
  logic               ended;
  logic [SW+5:0]      slen_ext;

  assign s_ready = !res_valid || dout.ready;
  assign take = s_valid && s_ready;
  assign dout.valid = res_valid;
  assign dout.data = res_item;
  assign slen_ext = {6'b0, status_count_next};

  always_comb begin
    header_count_next = header_count;
    last_bytes_next = last_bytes;
    status_count_next = status_count;
    status_open_next = status_open;
    in_body_next = in_body;
    body_total_next = body_total;
    ended = 1'b0;

    res_next.byte_out = s_item.data_byte;
    res_next.block_end = s_item.end_of_block;
    res_next.byte_class = CLS_HEADER;
    res_next.status_length = '0;
    res_next.header_gave_up = 1'b0;

    if (s_item.command == CMD_RESTART) begin
      header_count_next = '0;
      last_bytes_next = '0;
      status_count_next = '0;
      status_open_next = 1'b1;
      in_body_next = 1'b0;
      body_total_next = '0;
      res_next.byte_class = CLS_RESTART;
    end else if (in_body) begin
      body_total_next = body_total + 32'd1;
      res_next.byte_class = CLS_BODY;
    end else if (header_count >= header_limit) begin
      in_body_next = 1'b1;
      body_total_next = body_total + 32'd1;
      res_next.header_gave_up = 1'b1;
      res_next.byte_class = CLS_BODY;
    end else begin
      header_count_next = header_count + LIMIT_W'(1);
      last_bytes_next = {last_bytes[23:0], s_item.data_byte};
      if (status_open) begin
        if (s_item.data_byte == CH_CR || s_item.data_byte == CH_LF ||
            s_item.data_byte == CH_NUL) begin
          status_open_next = 1'b0;
        end else if (status_count < SMAX) begin
          status_count_next = status_count + SW'(1);
          res_next.byte_class = CLS_STATUS;
        end
      end
      ended = (header_count_next >= LIMIT_W'(4) && last_bytes_next == END_CRLF) ||
              (header_count_next >= LIMIT_W'(2) && last_bytes_next[15:0] == END_LFLF);
      if (ended) begin
        in_body_next = 1'b1;
        res_next.byte_class = CLS_FINAL;
        res_next.status_length = slen_ext[5:0];
      end
    end

    res_next.body_count = body_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      last_bytes <= '0;
      status_count <= '0;
      status_open <= 1'b1;
      in_body <= 1'b0;
      body_total <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        header_count <= header_count_next;
        last_bytes <= last_bytes_next;
        status_count <= status_count_next;
        status_open <= status_open_next;
        in_body <= in_body_next;
        body_total <= body_total_next;
        res_valid <= 1'b1;
      end else if (dout.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_item <= res_next;
    end
  end

`ifndef SYNTH
  a_gave_up_is_body: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.header_gave_up) |-> (res_item.byte_class == CLS_BODY))
    else $error("gave-up flag on a non-body item");

  a_body_entered: assert property (@(posedge clk) disable iff (rst)
    (take && (res_next.byte_class == CLS_FINAL || res_next.header_gave_up)) |=> in_body)
    else $error("body not entered after header end");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (take && s_item.command == CMD_RESTART) |=>
      (header_count == '0 && status_open && !in_body && body_total == '0))
    else $error("restart did not clear state");

  a_status_bound: assert property (@(posedge clk) disable iff (rst)
    take |=> (status_count <= SMAX))
    else $error("status count beyond its maximum");
`endif

endmodule

/* src/http_header_body_splitter.sv */
// An accepted input item is held in the input stage register, and its result is
// registered in the classify stage result register, where dout can take it.
// Throughput: one item per cycle while dout is ready; the running header state
// updates in the classify stage as each item is taken, so items follow directly.
// Reset (rst, synchronous, active high) clears both stages, restores the
// header state to its start values and sets header_limit to 600.
// Top level of the HTTP header/body splitter.
module http_header_body_splitter import hhbs_pkg::*; #(
  parameter int STATUS_MAX = STATUS_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  hhbs_in_if.sink            din,
  hhbs_out_if.source         dout
);

  logic [LIMIT_W-1:0] header_limit;
  logic               s_valid;
  logic               s_ready;
  in_item_t           s_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      header_limit <= cfg_data;
    end
  end

  hhbs_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .s_ready (s_ready),
    .s_valid (s_valid),
    .s_item  (s_item)
  );

  hhbs_classify #(
    .STATUS_MAX (STATUS_MAX)
  ) u_classify (
    .clk          (clk),
    .rst          (rst),
    .header_limit (header_limit),
    .s_valid      (s_valid),
    .s_item       (s_item),
    .s_ready      (s_ready),
    .dout         (dout)
  );

endmodule
